### sv/rsi_pkg.sv
// Package for the Wilder relative strength index core.
// Holds field widths, register indexes, reset values and the zone codes.
// No dependencies; every other file of the block uses it.
`default_nettype none

package rsi_pkg;

	// Fixed widths of the stream and configuration fields.
	localparam int PRICE_PORT_W = 32;
	localparam int PERIOD_W     = 8;
	localparam int LEVEL_W      = 14;
	localparam int RSI_W        = 14;
	localparam int ZONE_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 14;

	// Default values of the module parameters.
	localparam int PRICE_WIDTH_DEF   = 32;
	localparam int AVG_FRAC_BITS_DEF = 16;

	// Headroom over the price width for the warm-up sums (up to 255 changes).
	localparam int SUM_HEADROOM = 8;

	// Full scale of the index in hundredths.
	localparam logic [RSI_W-1:0] RSI_FULL = 14'd10000;

	// Reset values of the configuration registers.
	localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd14;
	localparam logic [LEVEL_W-1:0]  OVERBOUGHT_RST = 14'd7000;
	localparam logic [LEVEL_W-1:0]  OVERSOLD_RST   = 14'd3000;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN     = 8'd2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PERIOD     = 2'd0,
		CFG_OVERBOUGHT = 2'd1,
		CFG_OVERSOLD   = 2'd2
	} cfg_idx_t;

	// Zone codes of a result word.
	typedef enum logic [ZONE_W-1:0] {
		ZONE_NEUTRAL    = 2'd0,
		ZONE_OVERBOUGHT = 2'd1,
		ZONE_OVERSOLD   = 2'd2
	} zone_t;

endpackage

`default_nettype wire

### sv/rsi_if.sv
// Stream and configuration interfaces of the relative strength index core.
// Depends on rsi_pkg for the field widths.
`default_nettype none

// Price stream: one price word per handshake.
interface rsi_price_if;
	logic                             valid;
	logic                             ready;
	logic [rsi_pkg::PRICE_PORT_W-1:0] price;

	modport source (output valid, output price, input ready);
	modport sink (input valid, input price, output ready);
endinterface

// Result stream: one index and zone word per handshake.
interface rsi_result_if;
	logic                       valid;
	logic                       ready;
	logic [rsi_pkg::RSI_W-1:0]  rsi_hundredths;
	logic [rsi_pkg::ZONE_W-1:0] zone;

	modport source (output valid, output rsi_hundredths, output zone, input ready);
	modport sink (input valid, input rsi_hundredths, input zone, output ready);
endinterface

// Configuration write channel: register index and write data.
interface rsi_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rsi_pkg::CFG_IDX_W-1:0]  index;
	logic [rsi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/rsi_div.sv
// Shared iterative restoring divider, one quotient bit per clock cycle.
// Depends on rsi_pkg only through the import convention; widths come from parameters.
`default_nettype none

module rsi_div #(
	parameter int NW  = 70,
	parameter int DVW = 57,
	parameter int CW  = 7
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [NW-1:0]  dividend,
	input  wire logic [DVW-1:0] divisor,
	input  wire logic [CW-1:0]  iters,
	output logic                done,
	output logic [NW-1:0]       quot
);
	import rsi_pkg::*;

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [NW-1:0]  sh_q;

	logic [DVW:0]   trial;
	logic [DVW:0]   diff;
	logic           ge;
	logic [CW-1:0]  lshift;

	// Trial subtraction of the divisor from the partial remainder.
	assign trial  = {rem_q, sh_q[NW-1]};
	assign diff   = trial - {1'b0, dvs_q};
	assign ge     = trial >= {1'b0, dvs_q};
	assign lshift = CW'(NW) - iters;

	// Sequencing: count the requested number of quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: the upper dividend bits preload the remainder, the rest are shifted in
	// while the quotient bits enter at the bottom of the same register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DVW'(dividend >> iters);
			sh_q  <= dividend << lshift;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
			sh_q  <= {sh_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

`default_nettype wire

### sv/rsi_seq.sv
// Sequencer and state of the relative strength index core: price history,
// warm-up sums, Wilder averages and the result register. Drives the shared divider.
// Depends on rsi_pkg.
`default_nettype none

module rsi_seq #(
	parameter int PW  = 32,
	parameter int FB  = 16,
	parameter int NW  = 70,
	parameter int DVW = 57,
	parameter int CW  = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [PW-1:0]                 in_price,
	input  wire logic [rsi_pkg::PERIOD_W-1:0]  period,
	input  wire logic [rsi_pkg::LEVEL_W-1:0]   overbought_level,
	input  wire logic [rsi_pkg::LEVEL_W-1:0]   oversold_level,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rsi_pkg::RSI_W-1:0]          out_rsi,
	output rsi_pkg::zone_t                     out_zone,
	output logic                               div_start,
	output logic [NW-1:0]                      div_dividend,
	output logic [DVW-1:0]                     div_divisor,
	output logic [CW-1:0]                      div_iters,
	input  wire logic                          div_done,
	input  wire logic [NW-1:0]                 div_quot
);
	import rsi_pkg::*;

	localparam int AW = PW + SUM_HEADROOM + FB;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DIV_G  = 9'b000000010,
		ST_WAIT_G = 9'b000000100,
		ST_DIV_L  = 9'b000001000,
		ST_WAIT_L = 9'b000010000,
		ST_MUL    = 9'b000100000,
		ST_DIV_R  = 9'b001000000,
		ST_WAIT_R = 9'b010000000,
		ST_OUT    = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       prev_q;
	logic                first_q;
	logic                seeded_q;
	logic [PERIOD_W-1:0] cnt_q;
	logic [AW-1:0]       avg_g_q;
	logic [AW-1:0]       avg_l_q;
	logic [PW-1:0]       xg_q;
	logic [PW-1:0]       xl_q;
	logic                up_q;
	logic [NW-1:0]       prod_q;
	logic [DVW-1:0]      den_q;
	logic [RSI_W-1:0]    rsi_q;
	logic                out_valid_q;
	logic [RSI_W-1:0]    out_rsi_q;
	zone_t               out_zone_q;

	logic                accept;
	logic [PERIOD_W-1:0] eff_p;
	logic [PW-1:0]       gain;
	logic [PW-1:0]       loss;
	logic                seed_now;
	logic                sel_l;
	logic [AW-1:0]       op_a;
	logic [AW-1:0]       op_x;
	logic                up;
	logic [AW-1:0]       up_diff;
	logic [AW:0]         dn_sum;
	logic [AW-1:0]       quot_a;
	logic [AW-1:0]       upd;
	logic                out_load;
	zone_t               zone_c;

	// Price change split into a gain and a loss; a flat price is a zero loss.
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign eff_p    = (period < PERIOD_MIN) ? PERIOD_MIN : period;
	assign gain     = (in_price > prev_q) ? in_price - prev_q : '0;
	assign loss     = (in_price > prev_q) ? '0 : prev_q - in_price;
	assign seed_now = ({1'b0, cnt_q} + 9'd1) >= {1'b0, eff_p};

	// Operand selection for the gain and loss halves of the smoothing step.
	assign sel_l   = (state_q == ST_DIV_L) || (state_q == ST_WAIT_L);
	assign op_a    = sel_l ? avg_l_q : avg_g_q;
	assign op_x    = AW'(sel_l ? xl_q : xg_q) << FB;
	assign up      = op_x >= op_a;
	assign up_diff = op_x - op_a;
	assign dn_sum  = {1'b0, op_a} - {1'b0, op_x} + (AW+1)'(eff_p - 8'd1);
	assign quot_a  = div_quot[AW-1:0];
	assign upd     = up_q ? op_a + quot_a : op_a - quot_a;

	// Divider request: seed and smoothing divide by the period, the last step forms the ratio.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = prod_q;
		div_divisor  = DVW'(eff_p);
		div_iters    = CW'(AW);
		unique case (state_q)
			ST_DIV_G, ST_DIV_L: begin
				div_start = 1'b1;
				if (!seeded_q) begin
					div_dividend = NW'(op_a) << FB;
				end else if (up) begin
					div_dividend = NW'(up_diff);
				end else begin
					div_dividend = NW'(dn_sum);
				end
			end
			ST_DIV_R: begin
				div_start   = 1'b1;
				div_divisor = den_q;
				div_iters   = CW'(RSI_W);
			end
			default: begin
			end
		endcase
	end

	// Zone from the thresholds; overbought takes priority.
	always_comb begin
		if (rsi_q > overbought_level) begin
			zone_c = ZONE_OVERBOUGHT;
		end else if (rsi_q < oversold_level) begin
			zone_c = ZONE_OVERSOLD;
		end else begin
			zone_c = ZONE_NEUTRAL;
		end
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Control sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_q      <= '0;
			first_q     <= 1'b0;
			seeded_q    <= 1'b0;
			cnt_q       <= '0;
			avg_g_q     <= '0;
			avg_l_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q <= in_price;
						if (!first_q) begin
							first_q <= 1'b1;
						end else if (!seeded_q) begin
							avg_g_q <= avg_g_q + AW'(gain);
							avg_l_q <= avg_l_q + AW'(loss);
							cnt_q   <= cnt_q + 8'd1;
							if (seed_now) begin
								state_q <= ST_DIV_G;
							end
						end else begin
							state_q <= ST_DIV_G;
						end
					end
				end
				ST_DIV_G: begin
					state_q <= ST_WAIT_G;
				end
				ST_WAIT_G: begin
					if (div_done) begin
						avg_g_q <= seeded_q ? upd : quot_a;
						state_q <= ST_DIV_L;
					end
				end
				ST_DIV_L: begin
					state_q <= ST_WAIT_L;
				end
				ST_WAIT_L: begin
					if (div_done) begin
						avg_l_q  <= seeded_q ? upd : quot_a;
						seeded_q <= 1'b1;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (avg_l_q == '0) ? ST_OUT : ST_DIV_R;
				end
				ST_DIV_R: begin
					state_q <= ST_WAIT_R;
				end
				ST_WAIT_R: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: changes, direction, ratio operands and the result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			xg_q <= gain;
			xl_q <= loss;
		end
		if ((state_q == ST_DIV_G) || (state_q == ST_DIV_L)) begin
			up_q <= up;
		end
		if (state_q == ST_MUL) begin
			prod_q <= NW'(avg_g_q) * NW'(RSI_FULL);
			den_q  <= DVW'(avg_g_q) + DVW'(avg_l_q);
			rsi_q  <= RSI_FULL;
		end
		if ((state_q == ST_WAIT_R) && div_done) begin
			rsi_q <= div_quot[RSI_W-1:0];
		end
		if (out_load) begin
			out_rsi_q  <= rsi_q;
			out_zone_q <= zone_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsi   = out_rsi_q;
	assign out_zone  = out_zone_q;

endmodule

`default_nettype wire

### sv/wilder_rsi_indicator_core.sv
// Wilder relative strength index core. One price word goes in per handshake. The first price
// only primes the history; the next "period" changes are summed and divided by the period to
// seed the average gain and loss, and every later change applies Wilder smoothing. From the
// seeding price onwards each price yields one result word: the index in hundredths (10000 when
// the average loss is zero) and a zone code. Warm-up prices give no result. A single shared
// divider, which produces one quotient bit per cycle, serves the gain and loss divisions by
// the period and the final ratio. With a zero average loss the ratio division is skipped.
// The input is not ready while a price is being worked on; the result register lets the
// next price enter while a finished result waits. Configuration writes are always accepted.
// Depends on rsi_pkg, rsi_if, rsi_div and rsi_seq.
`default_nettype none

module wilder_rsi_indicator_core #(
	parameter int PRICE_WIDTH           = rsi_pkg::PRICE_WIDTH_DEF,
	parameter int AVERAGE_FRACTION_BITS = rsi_pkg::AVG_FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rsi_price_if.sink    prices,
	rsi_result_if.source results,
	rsi_cfg_if.sink      cfg
);
	import rsi_pkg::*;

	localparam int AW  = PRICE_WIDTH + SUM_HEADROOM + AVERAGE_FRACTION_BITS;
	localparam int DVW = AW + 1;
	localparam int NW  = AW + RSI_W;
	localparam int CW  = $clog2(NW + 1);

	logic [PERIOD_W-1:0]    period_q;
	logic [LEVEL_W-1:0]     overbought_q;
	logic [LEVEL_W-1:0]     oversold_q;
	logic [PRICE_WIDTH-1:0] price_w;
	zone_t                  zone_w;

	logic                   div_start;
	logic [NW-1:0]          div_dividend;
	logic [DVW-1:0]         div_divisor;
	logic [CW-1:0]          div_iters;
	logic                   div_done;
	logic [NW-1:0]          div_quot;

	// Configuration registers; an unknown index writes nothing.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_RST;
			overbought_q <= OVERBOUGHT_RST;
			oversold_q   <= OVERSOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_PERIOD:     period_q     <= cfg.data[PERIOD_W-1:0];
				CFG_OVERBOUGHT: overbought_q <= cfg.data[LEVEL_W-1:0];
				CFG_OVERSOLD:   oversold_q   <= cfg.data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Only the low PRICE_WIDTH bits of a price word take part.
	assign price_w = PRICE_WIDTH'(prices.price);

	// Sequencer with the averages and the result register.
	rsi_seq #(
		.PW  (PRICE_WIDTH),
		.FB  (AVERAGE_FRACTION_BITS),
		.NW  (NW),
		.DVW (DVW),
		.CW  (CW)
	) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (prices.valid),
		.in_ready         (prices.ready),
		.in_price         (price_w),
		.period           (period_q),
		.overbought_level (overbought_q),
		.oversold_level   (oversold_q),
		.out_valid        (results.valid),
		.out_ready        (results.ready),
		.out_rsi          (results.rsi_hundredths),
		.out_zone         (zone_w),
		.div_start        (div_start),
		.div_dividend     (div_dividend),
		.div_divisor      (div_divisor),
		.div_iters        (div_iters),
		.div_done         (div_done),
		.div_quot         (div_quot)
	);

	assign results.zone = zone_w;

	// Shared divider.
	rsi_div #(
		.NW  (NW),
		.DVW (DVW),
		.CW  (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (div_iters),
		.done     (div_done),
		.quot     (div_quot)
	);

endmodule

`default_nettype wire

### bench/tb_wilder_rsi_indicator_core.sv
// Self-checking testbench for wilder_rsi_indicator_core: warm-up, seeding, smoothing and zones.
// Predicts every result word in step with the stream and checks it field by field.
// Depends on rsi_pkg, rsi_if and the core with its submodules.

module tb_wilder_rsi_indicator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rsi_pkg::*;

	localparam int FRAC_BITS        = AVG_FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES     = 200;
	localparam int LONG_HOLD_CYCLES = 800;
	localparam int RANDOM_PHASES    = 14;
	localparam int PHASE_PRICES     = 40;
	localparam int CYCLE_LIMIT      = 1000000;

	typedef struct packed {
		logic [RSI_W-1:0] rsi;
		zone_t            zone;
	} rsi_word_t;

	logic clk;
	logic arst_n = 1'b0;

	rsi_price_if  price_ch ();
	rsi_result_if result_ch ();
	rsi_cfg_if    cfg_ch ();

	wilder_rsi_indicator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.prices  (price_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	// Predicted configuration and indicator state.
	logic [PERIOD_W-1:0] period_reg = PERIOD_RST;
	logic [LEVEL_W-1:0]  overbought_reg = OVERBOUGHT_RST;
	logic [LEVEL_W-1:0]  oversold_reg = OVERSOLD_RST;
	logic [31:0]         last_price = '0;
	logic [7:0]          changes_seen = '0;
	bit                  primed = 1'b0;
	bit                  seeded = 1'b0;
	logic [63:0]         gain_avg = '0;
	logic [63:0]         loss_avg = '0;

	rsi_word_t pending_rsi_words[$];

	// Run controls and tallies.
	bit          idle_enable = 1'b0;
	bit          long_hold_req = 1'b0;
	logic [31:0] walk_price = 32'd1000000;
	int          fail_count = 0;
	int          prices_sent = 0;
	int          words_checked = 0;
	int          reg_writes = 0;
	int          settings_used = 0;

	// Clock of 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle length for either side: mostly none, sometimes short, rarely long.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_enable || r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	// Wilder smoothing floor((a*(p-1) + x) / p) in exact integer terms.
	function automatic logic [63:0] wilder_smooth(logic [63:0] a, logic [63:0] x,
			logic [63:0] p);
		if (x >= a)
			return a + (x - a) / p;
		return a - ((a - x) + p - 1) / p;
	endfunction

	// Advances the predicted state by one accepted price and queues any result word.
	task automatic compute_rsi_word(input logic [31:0] price);
		logic [63:0] p, g, l, rsi;
		rsi_word_t   w;
		p = (period_reg < PERIOD_MIN) ? 64'(PERIOD_MIN) : 64'(period_reg);
		if (!primed) begin
			primed = 1'b1;
			last_price = price;
			return;
		end
		g = '0;
		l = '0;
		// A flat price counts as a zero loss.
		if (price > last_price)
			g = 64'(price - last_price);
		else
			l = 64'(last_price - price);
		last_price = price;
		if (!seeded) begin
			gain_avg = gain_avg + g;
			loss_avg = loss_avg + l;
			changes_seen = changes_seen + 8'd1;
			if (64'(changes_seen) < p)
				return;
			gain_avg = (gain_avg << FRAC_BITS) / p;
			loss_avg = (loss_avg << FRAC_BITS) / p;
			seeded = 1'b1;
		end else begin
			gain_avg = wilder_smooth(gain_avg, g << FRAC_BITS, p);
			loss_avg = wilder_smooth(loss_avg, l << FRAC_BITS, p);
		end
		// Full scale whenever the average loss is zero, even with no gain.
		if (loss_avg == 0)
			rsi = 64'(RSI_FULL);
		else
			rsi = (gain_avg * 64'd10000) / (gain_avg + loss_avg);
		w.rsi = rsi[RSI_W-1:0];
		// Overbought takes priority over oversold.
		if (w.rsi > overbought_reg)
			w.zone = ZONE_OVERBOUGHT;
		else if (w.rsi < oversold_reg)
			w.zone = ZONE_OVERSOLD;
		else
			w.zone = ZONE_NEUTRAL;
		pending_rsi_words.push_back(w);
	endtask

	// Offers one price word, waits for it to be taken and predicts its effect.
	task automatic send_price(input logic [31:0] p);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			price_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		price_ch.valid <= 1'b1;
		price_ch.price <= p;
		do @(posedge clk); while (!price_ch.ready);
		compute_rsi_word(p);
		prices_sent++;
	endtask

	// Writes one configuration register; valid is left high for a following write.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_PERIOD: begin
				period_reg = data[PERIOD_W-1:0];
			end
			CFG_OVERBOUGHT: begin
				overbought_reg = data[LEVEL_W-1:0];
			end
			CFG_OVERSOLD: begin
				oversold_reg = data[LEVEL_W-1:0];
			end
			default: begin
			end
		endcase
		reg_writes++;
	endtask

	// Writes all three registers back to back; only called with the core idle.
	task automatic configure(input logic [CFG_DATA_W-1:0] period_data,
			input logic [LEVEL_W-1:0] ob, input logic [LEVEL_W-1:0] os);
		write_reg(CFG_PERIOD, period_data);
		write_reg(CFG_OVERBOUGHT, ob);
		write_reg(CFG_OVERSOLD, os);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// Stops offering prices, waits for every predicted word, then lets the core go quiet.
	task automatic settle();
		price_ch.valid <= 1'b0;
		while (pending_rsi_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// A random level: extremes, values above full scale, or anything in range.
	function automatic logic [LEVEL_W-1:0] random_level();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return RSI_FULL;
			2: return {LEVEL_W{1'b1}};
			3: return LEVEL_W'($urandom_range(10001, 16383));
			default: return LEVEL_W'($urandom_range(0, 10000));
		endcase
	endfunction

	// Warm-up with flat prices, a period change before the seed and a period below two.
	task automatic test_warmup_and_seed();
		idle_enable = 1'b0;
		configure(14'd5, 14'd10001, 14'd0);
		send_price(32'd5);
		send_price(32'd5);
		send_price(32'd5);
		settle();
		// Period 1 acts as 2, so the next change seeds with zero gain and zero loss.
		configure(14'd1, 14'd10001, 14'd0);
		send_price(32'd5);
		send_price(32'hFFFF_FFFF);
		send_price(32'd0);
		send_price(32'h8000_0000);
		send_price(32'h8000_0000);
		settle();
	endtask

	// Zone priority with crossed levels, period changes after seeding and masked data.
	task automatic test_zones_and_periods();
		idle_enable = 1'b1;
		configure(14'd255, 14'd0, {LEVEL_W{1'b1}});
		send_price(32'h8000_0010);
		send_price(32'h8000_0000);
		send_price(32'hFFFF_FFFF);
		send_price(32'd0);
		send_price(32'd0);
		settle();
		// Upper data bits of the period write are dropped, leaving a period of 3.
		configure({6'h3F, 8'd3}, RSI_FULL, RSI_FULL);
		send_price(32'd100);
		send_price(32'd200);
		send_price(32'd150);
		send_price(32'd400);
		settle();
		configure(14'd0, {LEVEL_W{1'b1}}, 14'd0);
		send_price(32'h5555_5555);
		send_price(32'hAAAA_AAAA);
		send_price(32'h0000_0001);
		settle();
	endtask

	// Results held back for a long stretch while prices keep coming, so the core stalls.
	task automatic test_result_backpressure();
		idle_enable = 1'b0;
		configure(14'(PERIOD_RST), OVERBOUGHT_RST, OVERSOLD_RST);
		long_hold_req = 1'b1;
		for (int i = 0; i < 16; i++) begin
			walk_price = walk_price + 32'($urandom_range(0, 20)) - 32'd10;
			send_price(walk_price);
		end
		settle();
	endtask

	// Random settings, each followed by a run of prices in one of several styles.
	task automatic test_random_phases();
		int          style, bias, hi_bits;
		logic [7:0]  per;
		logic [13:0] ob, os;
		logic [31:0] step;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0: per = 8'd0;
				1: per = 8'd1;
				2: per = 8'd2;
				3: per = 8'd255;
				4, 5, 6: per = 8'($urandom_range(3, 20));
				default: per = 8'($urandom_range(2, 255));
			endcase
			hi_bits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : 0;
			if ($urandom_range(0, 9) < 6) begin
				ob = 14'($urandom_range(5000, 9500));
				os = 14'($urandom_range(500, 5000));
			end else begin
				ob = random_level();
				os = random_level();
			end
			configure({hi_bits[5:0], per}, ob, os);
			idle_enable = ($urandom_range(0, 3) != 0);
			style = $urandom_range(0, 3);
			bias = $urandom_range(5, 95);
			for (int i = 0; i < PHASE_PRICES; i++) begin
				case (style)
					0: begin
						walk_price = $urandom();
					end
					1, 2: begin
						// Biased walk, with a rare jump anywhere in range.
						step = (style == 1) ? $urandom_range(0, 50) : $urandom_range(0, 100000);
						if ($urandom_range(0, 99) < bias)
							walk_price = walk_price + step;
						else
							walk_price = walk_price - step;
						if ($urandom_range(0, 49) == 0)
							walk_price = $urandom();
					end
					default: begin
						// Nearly flat prices with many zero changes.
						walk_price = walk_price + 32'($urandom_range(0, 2)) - 32'd1;
					end
				endcase
				send_price(walk_price);
			end
			settle();
		end
	endtask

	// Result ready: random stalls, or one long hold when a test asks for it.
	initial begin : result_ready_driver
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = idle_length();
			end
		end
	end

	// Each accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin : result_checker
		rsi_word_t w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_rsi_words.size() == 0) begin
				$error("unexpected result word: rsi_hundredths %0d, zone %0d",
					result_ch.rsi_hundredths, result_ch.zone);
				fail_count++;
			end else begin
				w = pending_rsi_words.pop_front();
				words_checked++;
				if (result_ch.rsi_hundredths !== w.rsi) begin
					$error("rsi_hundredths mismatch: expected %0d, actual %0d",
						w.rsi, result_ch.rsi_hundredths);
					fail_count++;
				end
				if (result_ch.zone !== w.zone) begin
					$error("zone mismatch: expected %0d, actual %0d", w.zone, result_ch.zone);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles with %0d words outstanding", CYCLE_LIMIT,
			pending_rsi_words.size());
		$display("wilder_rsi_indicator_core verification failed");
		$finish;
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		price_ch.valid <= 1'b0;
		price_ch.price <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= CFG_PERIOD;
		cfg_ch.data    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_warmup_and_seed();
		test_zones_and_periods();
		test_result_backpressure();
		test_random_phases();
		settle();

		$display("Run covered %0d prices and %0d result words under %0d settings (%0d writes),",
			prices_sent, words_checked, settings_used, reg_writes);
		$display("including warm-up, seeding, crossed and out-of-range levels and a long stall.");
		if (fail_count == 0)
			$display("wilder_rsi_indicator_core verification clean");
		else
			$display("wilder_rsi_indicator_core verification failed");
		$finish;
	end

endmodule
